[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES  = 65536;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  // page number width across the whole 32-bit address space
  localparam int APN_W      = ADDR_W - PAGE_SHIFT;

  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [ADDR_W-1:0] NUM_PAGES_A = ADDR_W'(NUM_PAGES);
  localparam logic [ADDR_W-1:0] LAST_PAGE_A = ADDR_W'(NUM_PAGES - 1);
  localparam logic [ADDR_W-1:0] USABLE_RAM  = ADDR_W'(1);

  typedef enum logic [1:0] {
    KIND_FREE    = 2'd0,
    KIND_RESERVE = 2'd1,
    KIND_ALLOC   = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] region_type;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] region_length;
    logic [ADDR_W-1:0] end_addr;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic              found;
  } out_beat_t;

  // inclusive page range in address-space page numbers
  typedef struct packed {
    logic             vld;
    logic [APN_W-1:0] lo;
    logic [APN_W-1:0] hi;
  } seg_t;

  typedef struct packed {
    logic alloc;
    logic set_val;
    seg_t seg_a;
    seg_t seg_b;
  } op_t;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEG,
    ST_RD,
    ST_WR,
    ST_ARD,
    ST_ACHK,
    ST_DONE
  } state_t;

endpackage

[rtl/bpa_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// bpa_bitmap_ram
// Single-port bitmap store, one used bit per page, registered read data.
// ----------------------------------------------------------------------------
module bpa_bitmap_ram (
  input  logic                                 clk,
  input  bpa_pkg::mem_req_t                    req,
  output logic [bpa_pkg::WORD_W-1:0]           rdata
);

  logic [bpa_pkg::WORD_W-1:0] mem [bpa_pkg::NUM_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.addr];
  end

endmodule

[rtl/bpa_decode.sv]
// ----------------------------------------------------------------------------
// bpa_decode
// Turns one input beat into up to two page ranges and an operation.
// ----------------------------------------------------------------------------
module bpa_decode (
  input  bpa_pkg::in_beat_t in_beat,
  output bpa_pkg::op_t      op
);

  localparam int AW = bpa_pkg::ADDR_W;
  localparam int PW = bpa_pkg::APN_W;
  localparam int PS = bpa_pkg::PAGE_SHIFT;

  logic [PW-1:0] start_pg;
  logic [PW-1:0] last_pg;
  logic [AW-1:0] len_m1;
  logic [PW:0]   end_sum;
  logic          wrap;
  logic          in_order;
  logic          low_past;
  logic [PW-1:0] end_pg;

  always_comb begin
    start_pg = in_beat.start_addr[AW-1:PS];
    last_pg  = in_beat.end_addr[AW-1:PS];
    len_m1   = in_beat.region_length - AW'(1);
    // free region covers ceil(len / page) pages, wrapping at the top
    end_sum  = {1'b0, start_pg} + {1'b0, len_m1[AW-1:PS]};
    wrap     = end_sum[PW];
    in_order = in_beat.start_addr <= in_beat.end_addr;
    // the walk misses the last page when its offset is past the end offset
    low_past = in_beat.start_addr[PS-1:0] > in_beat.end_addr[PS-1:0];
    end_pg   = last_pg - PW'(low_past);

    op = '0;
    case (bpa_pkg::kind_t'(in_beat.kind))
      bpa_pkg::KIND_FREE: begin
        op.set_val   = 1'b0;
        op.seg_a.vld = (in_beat.region_type == bpa_pkg::USABLE_RAM) &&
                       (in_beat.region_length != '0);
        op.seg_a.lo  = start_pg;
        op.seg_a.hi  = wrap ? '1 : end_sum[PW-1:0];
        op.seg_b.vld = op.seg_a.vld && wrap;
        op.seg_b.lo  = '0;
        op.seg_b.hi  = end_sum[PW-1:0];
      end
      bpa_pkg::KIND_RESERVE: begin
        op.set_val   = 1'b1;
        op.seg_a.vld = in_order;
        op.seg_a.lo  = start_pg;
        op.seg_a.hi  = end_pg;
        // page zero is always locked
        op.seg_b.vld = 1'b1;
        op.seg_b.lo  = '0;
        op.seg_b.hi  = '0;
      end
      bpa_pkg::KIND_ALLOC: begin
        op.alloc = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
  end

endmodule

[rtl/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: reset fill, word-wise read-modify-write of page ranges and
// first-fit scan for allocation.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpa_pkg::op_t                  op,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          res_space,
  output logic                          done,
  output bpa_pkg::out_beat_t            res,
  output bpa_pkg::mem_req_t             mem_req,
  input  logic [bpa_pkg::WORD_W-1:0]    mem_rdata
);

  localparam int AW = bpa_pkg::ADDR_W;
  localparam int PW = bpa_pkg::APN_W;
  localparam int WW = bpa_pkg::WORD_W;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int XW = bpa_pkg::WADDR_W;
  localparam logic [XW-1:0] LAST_WORD = XW'(bpa_pkg::NUM_WORDS - 1);

  bpa_pkg::state_t    state_r, state_nxt;
  bpa_pkg::op_t       op_r, op_nxt;
  logic               seg_sel_r, seg_sel_nxt;
  logic [XW-1:0]      word_r, word_nxt;
  logic [PW-1:0]      lo_r, lo_nxt;
  logic [PW-1:0]      hi_r, hi_nxt;
  bpa_pkg::out_beat_t res_r, res_nxt;

  bpa_pkg::seg_t      cur;
  logic [XW-1:0]      lo_w;
  logic [XW-1:0]      hi_w;
  logic [BW-1:0]      lo_b;
  logic [BW-1:0]      hi_b;
  logic [WW-1:0]      mask;
  logic [WW-1:0]      zeros;
  logic [WW-1:0]      low_zero;
  logic [BW-1:0]      zero_ix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bpa_pkg::ST_INIT;
      word_r    <= '0;
      seg_sel_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      word_r    <= word_nxt;
      seg_sel_r <= seg_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    res_r <= res_nxt;
  end

  // bit mask of the pages of the current range inside word_r
  always_comb begin
    lo_w = XW'(lo_r >> BW);
    hi_w = XW'(hi_r >> BW);
    lo_b = (word_r == lo_w) ? lo_r[BW-1:0] : '0;
    hi_b = (word_r == hi_w) ? hi_r[BW-1:0] : '1;
    mask = ({WW{1'b1}} << lo_b) & ({WW{1'b1}} >> (BW'(WW - 1) - hi_b));
  end

  // lowest clear bit of the word just read
  always_comb begin
    zeros    = ~mem_rdata;
    low_zero = zeros & (~zeros + WW'(1));
    zero_ix  = '0;
    for (int i = 0; i < WW; i++) begin
      if (low_zero[i]) begin
        zero_ix = zero_ix | BW'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    seg_sel_nxt = seg_sel_r;
    word_nxt    = word_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    done        = 1'b0;
    mem_req     = '0;
    mem_req.addr = word_r;
    cur         = seg_sel_r ? op_r.seg_b : op_r.seg_a;

    case (state_r)
      bpa_pkg::ST_INIT: begin
        // every page starts out used
        mem_req.we    = 1'b1;
        mem_req.wdata = '1;
        word_nxt      = word_r + XW'(1);
        if (word_r == LAST_WORD) begin
          word_nxt  = '0;
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt      = op;
          res_nxt     = '0;
          seg_sel_nxt = 1'b0;
          word_nxt    = '0;
          state_nxt   = op.alloc ? bpa_pkg::ST_ARD : bpa_pkg::ST_SEG;
        end
      end
      bpa_pkg::ST_SEG: begin
        if (!cur.vld || ({{(AW-PW){1'b0}}, cur.lo} >= bpa_pkg::NUM_PAGES_A)) begin
          seg_sel_nxt = 1'b1;
          state_nxt   = seg_sel_r ? bpa_pkg::ST_DONE : bpa_pkg::ST_SEG;
        end else begin
          lo_nxt = cur.lo;
          hi_nxt = ({{(AW-PW){1'b0}}, cur.hi} >= bpa_pkg::LAST_PAGE_A) ?
                   PW'(bpa_pkg::NUM_PAGES - 1) : cur.hi;
          word_nxt  = XW'(cur.lo >> BW);
          state_nxt = bpa_pkg::ST_RD;
        end
      end
      bpa_pkg::ST_RD: begin
        state_nxt = bpa_pkg::ST_WR;
      end
      bpa_pkg::ST_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = op_r.set_val ? (mem_rdata | mask) : (mem_rdata & ~mask);
        if (word_r == hi_w) begin
          seg_sel_nxt = 1'b1;
          state_nxt   = seg_sel_r ? bpa_pkg::ST_DONE : bpa_pkg::ST_SEG;
        end else begin
          word_nxt  = word_r + XW'(1);
          state_nxt = bpa_pkg::ST_RD;
        end
      end
      bpa_pkg::ST_ARD: begin
        state_nxt = bpa_pkg::ST_ACHK;
      end
      bpa_pkg::ST_ACHK: begin
        if (mem_rdata != '1) begin
          mem_req.we        = 1'b1;
          mem_req.wdata     = mem_rdata | low_zero;
          res_nxt.found     = 1'b1;
          res_nxt.page_addr = AW'({word_r, zero_ix}) << bpa_pkg::PAGE_SHIFT;
          state_nxt         = bpa_pkg::ST_DONE;
        end else if (word_r == LAST_WORD) begin
          state_nxt = bpa_pkg::ST_DONE;
        end else begin
          word_nxt  = word_r + XW'(1);
          state_nxt = bpa_pkg::ST_ARD;
        end
      end
      bpa_pkg::ST_DONE: begin
        if (res_space) begin
          done      = 1'b1;
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

[rtl/bitmap_page_allocator.sv]
// Free and reserve read, then write back, each 64-page bitmap word touched;
// allocate reads words in turn, up to 1024 words, and sets the lowest clear bit.
// One item at a time; each access of the single-port bitmap RAM is one read or
// one write. The next item is taken while the previous result waits. After
// rst_n the RAM is filled with ones, word by word, before the first item is
// taken.
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page-frame bitmap allocator: region free, range reserve, first-fit alloc.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpa_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output bpa_pkg::out_beat_t out_beat
);

  bpa_pkg::op_t       op;
  bpa_pkg::mem_req_t  mem_req;
  logic [bpa_pkg::WORD_W-1:0] mem_rdata;
  logic               res_space;
  logic               done;
  bpa_pkg::out_beat_t res;

  logic               out_valid_r, out_valid_nxt;
  bpa_pkg::out_beat_t out_beat_r, out_beat_nxt;

  bpa_decode u_decode (
    .in_beat (in_beat),
    .op      (op)
  );

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_space (res_space),
    .done      (done),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bpa_bitmap_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // result beat register
  always_comb begin
    res_space     = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    out_beat_nxt  = out_beat_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before its beat was taken");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.found |-> out_beat.page_addr == '0)
    else $error("page address without a found page");

  a_hit_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.found |->
      out_beat.page_addr[bpa_pkg::PAGE_SHIFT-1:0] == '0)
    else $error("allocated address not page aligned");

endmodule

[bench/bitmap_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Self-checking bench for the page allocator. A bitmap predictor follows every
// beat sent; each result beat is checked against it in order. Covers region
// types, unaligned and wrapping regions, pages past capacity, reserve ranges,
// allocation from empty and full maps, random traffic and output back-pressure.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 850;
  localparam int PS             = bpa_pkg::PAGE_SHIFT;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  bpa_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bpa_pkg::out_beat_t out_beat;

  // predicted page map, 1 = used
  bit                 page_taken [bpa_pkg::NUM_PAGES];
  int unsigned        free_pages;
  bpa_pkg::out_beat_t expected_grants [$];
  bpa_pkg::out_beat_t exp_grant;
  int unsigned        mismatches  = 0;
  int unsigned        idle_cycles = 0;
  bit                 no_idle     = 1'b0;
  bit                 hold_req    = 1'b0;
  bit                 hold_done   = 1'b0;

  bitmap_page_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #6 clk = ~clk;

  function automatic void set_page(input longint unsigned pg, input bit v);
    if (pg >= bpa_pkg::NUM_PAGES) return;
    if (page_taken[pg] != v) begin
      page_taken[pg] = v;
      if (v) free_pages--;
      else free_pages++;
    end
  endfunction

  // inclusive page span, clipped to capacity
  function automatic void mark_span(input longint unsigned lo, input longint unsigned hi,
                                    input bit v);
    longint unsigned p;
    longint unsigned top;
    if (lo >= bpa_pkg::NUM_PAGES) return;
    top = (hi >= bpa_pkg::NUM_PAGES) ? 64'(bpa_pkg::NUM_PAGES - 1) : hi;
    for (p = lo; p <= top; p++) set_page(p, v);
  endfunction

  function automatic bpa_pkg::out_beat_t predict_grant(input bpa_pkg::in_beat_t b);
    bpa_pkg::out_beat_t r;
    longint unsigned    first;
    longint unsigned    count;
    longint unsigned    span;
    longint unsigned    p;
    r     = '0;
    span  = 64'd1 << bpa_pkg::APN_W;
    first = 64'(b.start_addr >> PS);
    case (bpa_pkg::kind_t'(b.kind))
      bpa_pkg::KIND_FREE: begin
        if (b.region_type == bpa_pkg::USABLE_RAM) begin
          count = ({32'd0, b.region_length} + 64'(bpa_pkg::PAGE_BYTES - 1)) >> PS;
          if (count >= span) begin
            mark_span(64'd0, 64'(bpa_pkg::NUM_PAGES - 1), 1'b0);
          end else if (count != 0) begin
            // the walk wraps at the top of the address space
            if (first + count <= span) begin
              mark_span(first, first + count - 1, 1'b0);
            end else begin
              mark_span(first, span - 1, 1'b0);
              mark_span(64'd0, first + count - 1 - span, 1'b0);
            end
          end
        end
      end
      bpa_pkg::KIND_RESERVE: begin
        if (b.start_addr <= b.end_addr)
          mark_span(first, first + 64'((b.end_addr - b.start_addr) >> PS), 1'b1);
        set_page(64'd0, 1'b1);
      end
      bpa_pkg::KIND_ALLOC: begin
        if (free_pages != 0) begin
          p = '0;
          while (page_taken[p]) p++;
          set_page(p, 1'b1);
          r.page_addr = 32'(p << PS);
          r.found     = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bpa_pkg::in_beat_t make_beat(input bpa_pkg::kind_t k,
                                                  input logic [31:0] rtype,
                                                  input logic [31:0] start,
                                                  input logic [31:0] len,
                                                  input logic [31:0] last);
    bpa_pkg::in_beat_t b;
    b.kind          = k;
    b.region_type   = rtype;
    b.start_addr    = start;
    b.region_length = len;
    b.end_addr      = last;
    return b;
  endfunction

  function automatic bpa_pkg::in_beat_t random_item();
    bpa_pkg::in_beat_t b;
    int unsigned       pick;
    b.kind          = bpa_pkg::KIND_NOP;
    b.region_type   = $urandom();
    b.start_addr    = $urandom();
    b.region_length = $urandom();
    b.end_addr      = $urandom();
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      b.kind = bpa_pkg::KIND_ALLOC;
    end else if (pick < 70) begin
      // usable region in low memory, mostly page aligned
      b.kind        = bpa_pkg::KIND_FREE;
      b.region_type = bpa_pkg::USABLE_RAM;
      b.start_addr  = 32'($urandom_range(4095, 0)) << PS;
      if ($urandom_range(3, 0) == 0) b.start_addr[PS-1:0] = PS'($urandom());
      b.region_length = $urandom_range(16 * bpa_pkg::PAGE_BYTES, 0);
    end else if (pick < 82) begin
      b.kind       = bpa_pkg::KIND_RESERVE;
      b.start_addr = 32'($urandom_range(4095, 0)) << PS;
      if ($urandom_range(3, 0) == 0) b.start_addr[PS-1:0] = PS'($urandom());
      b.end_addr = b.start_addr + $urandom_range(8 * bpa_pkg::PAGE_BYTES, 0);
      if ($urandom_range(7, 0) == 0)
        b.end_addr = b.start_addr - $urandom_range(bpa_pkg::PAGE_BYTES, 1);
    end else if (pick < 88) begin
      b.kind = bpa_pkg::KIND_FREE;
      if ($urandom_range(1, 0) == 0) b.region_type = $urandom_range(3, 0);
    end else if (pick < 92) begin
      b.kind = bpa_pkg::KIND_RESERVE;
    end else if (pick < 96) begin
      b.kind        = bpa_pkg::KIND_FREE;
      b.region_type = bpa_pkg::USABLE_RAM;
    end
    return b;
  endfunction

  task automatic send_item(input bpa_pkg::in_beat_t b);
    while (!no_idle && $urandom_range(99, 0) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    expected_grants.push_back(predict_grant(b));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_reset_state();
    send_item(make_beat(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0));
    send_item(make_beat(bpa_pkg::KIND_NOP, $urandom(), $urandom(), $urandom(),
                        $urandom()));
  endtask

  task automatic test_region_types();
    send_item(make_beat(bpa_pkg::KIND_FREE, 32'd0, 32'h0, 32'h10000, 32'h0));
    send_item(make_beat(bpa_pkg::KIND_FREE, 32'd2, 32'h0, 32'h10000, 32'h0));
    send_item(make_beat(bpa_pkg::KIND_FREE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                        32'h0));
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0, 32'h0,
                        32'hFFFF_FFFF));
  endtask

  task automatic test_free_and_alloc();
    // unaligned start reaches into the next page
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0000_0FFF,
                        32'h1001, 32'h0));
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0000_2000,
                        32'h1, 32'h0));
    repeat (4) send_item(make_beat(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0));
  endtask

  task automatic test_address_wrap();
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'hFFFF_F800,
                        32'h2000, 32'h0));
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0FFF_F000,
                        32'h1000, 32'h0));
    // past capacity, no effect
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h1000_0000,
                        32'h10000, 32'h0));
    repeat (2) send_item(make_beat(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0));
  endtask

  task automatic test_reserve_ranges();
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0,
                        32'hFFFF_FFFF, 32'h0));
    send_item(make_beat(bpa_pkg::KIND_RESERVE, 0, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_beat(bpa_pkg::KIND_FREE, bpa_pkg::USABLE_RAM, 32'h0,
                        32'hFFFF_FFFF, 32'h0));
    // start above end still locks page zero
    send_item(make_beat(bpa_pkg::KIND_RESERVE, 0, 32'h5000, 32'h0, 32'h1000));
    send_item(make_beat(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0));
    send_item(make_beat(bpa_pkg::KIND_RESERVE, 0, 32'hFFFF_F000, 32'h0,
                        32'hFFFF_FFFF));
    send_item(make_beat(bpa_pkg::KIND_RESERVE, 0, 32'h2000, 32'h0, 32'h2FFF));
    send_item(make_beat(bpa_pkg::KIND_ALLOC, 0, 0, 0, 0));
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 500);
      send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (24) send_item(random_item());
  endtask

  // result side ready, with a long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(99, 0) >= 16);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got addr %h found %b",
                 $time, out_beat.page_addr, out_beat.found);
        mismatches++;
      end else begin
        exp_grant = expected_grants.pop_front();
        if (out_beat.page_addr !== exp_grant.page_addr) begin
          $display("%0t: page_addr mismatch, expected %h, actual %h",
                   $time, exp_grant.page_addr, out_beat.page_addr);
          mismatches++;
        end
        if (out_beat.found !== exp_grant.found) begin
          $display("%0t: found mismatch, expected %b, actual %b",
                   $time, exp_grant.found, out_beat.found);
          mismatches++;
        end
      end
    end
  end

  // covers the fill after reset and a full-map scan
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (page_taken[i]) page_taken[i] = 1'b1;
    free_pages = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_region_types();
    test_free_and_alloc();
    test_address_wrap();
    test_reserve_ranges();
    test_random_mix();
    test_output_stall();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
